// ===== rtl/grid_line_of_sight_defines.svh =====
// Assertion macros shared by the grid line of sight RTL.
`ifndef GRID_LINE_OF_SIGHT_DEFINES_SVH
`define GRID_LINE_OF_SIGHT_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define GLS_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("grid_line_of_sight: assertion failed");

// Check that a condition implies a result in the same cycle.
`define GLS_ASSERT_IMPL(label, cond, res) \
    `GLS_ASSERT(label, (cond) |-> (res))

// Check that a condition implies a result in the next cycle.
`define GLS_ASSERT_NEXT(label, cond, res) \
    `GLS_ASSERT(label, (cond) |=> (res))

`else

`define GLS_ASSERT(label, prop)
`define GLS_ASSERT_IMPL(label, cond, res)
`define GLS_ASSERT_NEXT(label, cond, res)

`endif

`endif

// ===== rtl/gls_pkg.sv =====
// Shared constants, codes and control/status types for the grid line of sight block.
package gls_pkg;

    localparam int MAP_WIDTH  = 128;
    localparam int MAP_HEIGHT = 64;
    localparam int MAP_CELLS  = MAP_WIDTH * MAP_HEIGHT;

    localparam int CX_W   = 7;            // column field width
    localparam int CY_W   = 6;            // row field width
    localparam int PX_W   = CX_W + 2;     // signed walk column, one cell off the map
    localparam int PY_W   = CY_W + 2;     // signed walk row
    localparam int ERR_W  = CX_W + 3;     // signed error term
    localparam int ADDR_W = CX_W + CY_W;
    localparam int CFG_W  = 7;            // widest register
    localparam int IDX_W  = 2;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_MOVE  = 2'd1;
    localparam logic [1:0] CMD_VIEW  = 2'd2;

    localparam logic [IDX_W-1:0] REG_PLAYER_X     = 2'd0;
    localparam logic [IDX_W-1:0] REG_PLAYER_Y     = 2'd1;
    localparam logic [IDX_W-1:0] REG_PLAYER_VALID = 2'd2;

    typedef struct packed {
        logic load;        // capture a query
        logic write_cell;  // write the map cell
        logic advance;     // take the next line step, read its cell
        logic back_off;    // take back the minor step, read that cell
        logic finish;      // capture the walk result
        logic finish_now;  // capture the result of a write or unused command
    } gls_ctrl_t;

    typedef struct packed {
        logic step_zero;   // target equals start
        logic blocked;     // current cell is blocked
        logic at_target;   // current cell is the target
        logic need_back;   // blocked with negative error off the target
    } gls_stat_t;

endpackage

// ===== rtl/gls_ctrl.sv =====
// Controller state machine that sequences the line walk.
`include "grid_line_of_sight_defines.svh"

module gls_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            command,
    input  gls_pkg::gls_stat_t    stat,
    output gls_pkg::gls_ctrl_t    ctrl,
    output logic                  busy,
    output logic                  done
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADV  = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;
    localparam logic [1:0] ST_BACK = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       done_reg;
    logic       done_next;
    logic       is_query;

    assign is_query = (command == gls_pkg::CMD_MOVE) || (command == gls_pkg::CMD_VIEW);

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (is_query)
                    begin
                        ctrl.load  = 1'b1;
                        state_next = ST_ADV;
                    end
                    else
                    begin
                        ctrl.write_cell = (command == gls_pkg::CMD_WRITE);
                        ctrl.finish_now = 1'b1;
                    end
                end
            end
            ST_ADV:
            begin
                if (stat.step_zero)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    ctrl.advance = 1'b1;
                    state_next   = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (stat.need_back)
                begin
                    ctrl.back_off = 1'b1;
                    state_next    = ST_BACK;
                end
                else if (stat.at_target || stat.blocked)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    ctrl.advance = 1'b1;
                end
            end
            ST_BACK:
            begin
                if (stat.at_target || stat.blocked)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    ctrl.advance = 1'b1;
                    state_next   = ST_EVAL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done_next = ctrl.finish || ctrl.finish_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    `GLS_ASSERT_NEXT(a_query_goes_busy, start && !busy && is_query, busy && !done)
    `GLS_ASSERT_NEXT(a_write_answers_next, start && !busy && !is_query, done && !busy)
    `GLS_ASSERT_IMPL(a_done_when_idle, done, !busy)
    `GLS_ASSERT_NEXT(a_single_back_off, state_reg == ST_BACK, state_reg != ST_BACK)
    `GLS_ASSERT_IMPL(a_back_from_eval, state_reg == ST_BACK, $past(state_reg) == ST_EVAL)

endmodule

// ===== rtl/gls_datapath.sv =====
// Datapath: map memory, walk position and error term, blocked test and result registers.
module gls_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gls_pkg::gls_ctrl_t            ctrl,
    output gls_pkg::gls_stat_t            stat,
    input  logic [1:0]                    command,
    input  logic [gls_pkg::CX_W-1:0]      cell_x,
    input  logic [gls_pkg::CY_W-1:0]      cell_y,
    input  logic                          cell_move_blocked,
    input  logic                          cell_view_blocked,
    input  logic [gls_pkg::CX_W-1:0]      from_x,
    input  logic [gls_pkg::CY_W-1:0]      from_y,
    input  logic [gls_pkg::CX_W-1:0]      to_x,
    input  logic [gls_pkg::CY_W-1:0]      to_y,
    input  logic                          cfg_we,
    input  logic [gls_pkg::IDX_W-1:0]     cfg_index,
    input  logic [gls_pkg::CFG_W-1:0]     cfg_data,
    output logic                          target_reached,
    output logic [gls_pkg::CX_W-1:0]      end_x,
    output logic [gls_pkg::CY_W-1:0]      end_y
);

    localparam int CX_W  = gls_pkg::CX_W;
    localparam int CY_W  = gls_pkg::CY_W;
    localparam int PX_W  = gls_pkg::PX_W;
    localparam int PY_W  = gls_pkg::PY_W;
    localparam int ERR_W = gls_pkg::ERR_W;

    // map memory, bit 0 blocks movement, bit 1 blocks view
    logic [1:0]                  map_mem [gls_pkg::MAP_CELLS];
    logic [1:0]                  rd_data_reg;
    logic [gls_pkg::ADDR_W-1:0]  wr_addr;
    logic [gls_pkg::ADDR_W-1:0]  rd_addr;

    // player registers
    logic [CX_W-1:0] player_x_reg;
    logic [CY_W-1:0] player_y_reg;
    logic            player_valid_reg;

    // walk state
    logic signed [PX_W-1:0]  pos_x_reg, pos_x_next;
    logic signed [PY_W-1:0]  pos_y_reg, pos_y_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic [CX_W-1:0]         tgt_x_reg, tgt_x_next;
    logic [CY_W-1:0]         tgt_y_reg, tgt_y_next;
    logic [CX_W-1:0]         step_reg, step_next;
    logic [CX_W-1:0]         delta_reg, delta_next;
    logic                    major_x_reg, major_x_next;
    logic signed [1:0]       dir_x_reg, dir_x_next;
    logic signed [1:0]       dir_y_reg, dir_y_next;
    logic                    view_reg, view_next;

    // result registers
    logic            reached_reg, reached_next;
    logic [CX_W-1:0] end_x_reg, end_x_next;
    logic [CY_W-1:0] end_y_reg, end_y_next;

    // query setup
    logic signed [PX_W-1:0] dx;
    logic signed [PY_W-1:0] dy;
    logic [CX_W-1:0]        adx;
    logic [CY_W-1:0]        ady;
    logic                   setup_major_x;
    logic [CY_W-1:0]        setup_minor;

    // step arithmetic
    logic signed [PX_W-1:0]  major_dx, minor_dx;
    logic signed [PY_W-1:0]  major_dy, minor_dy;
    logic signed [ERR_W-1:0] step_s, two_step, err_add;
    logic                    diag;
    logic signed [PX_W-1:0]  adv_x, back_x;
    logic signed [PY_W-1:0]  adv_y, back_y;
    logic signed [ERR_W-1:0] adv_err, back_err;

    // cell test
    logic on_map;
    logic player_hit;
    logic blocked;
    logic at_target;

    assign dx  = $signed({2'b00, to_x}) - $signed({2'b00, from_x});
    assign dy  = $signed({2'b00, to_y}) - $signed({2'b00, from_y});
    assign adx = dx[PX_W-1] ? CX_W'(-dx) : CX_W'(dx);
    assign ady = dy[PY_W-1] ? CY_W'(-dy) : CY_W'(dy);
    assign setup_major_x = (adx > CX_W'(ady));
    // the minor distance never exceeds the row range
    assign setup_minor = setup_major_x ? ady : adx[CY_W-1:0];

    assign major_dx = major_x_reg ? PX_W'(dir_x_reg) : '0;
    assign major_dy = major_x_reg ? '0 : PY_W'(dir_y_reg);
    assign minor_dx = major_x_reg ? '0 : PX_W'(dir_x_reg);
    assign minor_dy = major_x_reg ? PY_W'(dir_y_reg) : '0;

    assign step_s   = $signed({{(ERR_W-CX_W){1'b0}}, step_reg});
    assign two_step = $signed({{(ERR_W-CX_W-1){1'b0}}, step_reg, 1'b0});
    assign err_add  = err_reg + $signed({{(ERR_W-CX_W){1'b0}}, delta_reg});
    assign diag     = (err_add > step_s);

    assign adv_x   = pos_x_reg + major_dx + (diag ? minor_dx : PX_W'(0));
    assign adv_y   = pos_y_reg + major_dy + (diag ? minor_dy : PY_W'(0));
    assign adv_err = diag ? (err_add - two_step) : err_add;

    assign back_x   = pos_x_reg - minor_dx;
    assign back_y   = pos_y_reg - minor_dy;
    assign back_err = err_reg + two_step;

    assign on_map = !pos_x_reg[PX_W-1] && (pos_x_reg < PX_W'(gls_pkg::MAP_WIDTH))
                 && !pos_y_reg[PY_W-1] && (pos_y_reg < PY_W'(gls_pkg::MAP_HEIGHT));
    assign player_hit = player_valid_reg
                     && (pos_x_reg[CX_W-1:0] == player_x_reg)
                     && (pos_y_reg[CY_W-1:0] == player_y_reg);
    assign blocked = !on_map || (view_reg ? rd_data_reg[1]
                                          : (rd_data_reg[0] || player_hit));
    assign at_target = (pos_x_reg == $signed({2'b00, tgt_x_reg}))
                    && (pos_y_reg == $signed({2'b00, tgt_y_reg}));

    assign stat.step_zero = (step_reg == '0);
    assign stat.blocked   = blocked;
    assign stat.at_target = at_target;
    assign stat.need_back = err_reg[ERR_W-1] && !at_target && blocked;

    // row-major index; the map width is a power of two
    assign wr_addr = {cell_y, cell_x};
    assign rd_addr = ctrl.back_off ? {back_y[CY_W-1:0], back_x[CX_W-1:0]}
                                   : {adv_y[CY_W-1:0], adv_x[CX_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (ctrl.write_cell)
        begin
            map_mem[wr_addr] <= {cell_view_blocked, cell_move_blocked};
        end
        rd_data_reg <= map_mem[rd_addr];
    end

    always_comb
    begin
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        err_next     = err_reg;
        tgt_x_next   = tgt_x_reg;
        tgt_y_next   = tgt_y_reg;
        step_next    = step_reg;
        delta_next   = delta_reg;
        major_x_next = major_x_reg;
        dir_x_next   = dir_x_reg;
        dir_y_next   = dir_y_reg;
        view_next    = view_reg;
        if (ctrl.load)
        begin
            pos_x_next   = $signed({2'b00, from_x});
            pos_y_next   = $signed({2'b00, from_y});
            err_next     = '0;
            tgt_x_next   = to_x;
            tgt_y_next   = to_y;
            major_x_next = setup_major_x;
            step_next    = setup_major_x ? adx : CX_W'(ady);
            delta_next   = {setup_minor, 1'b0};
            dir_x_next   = dx[PX_W-1] ? -2'sd1 : ((dx != '0) ? 2'sd1 : 2'sd0);
            dir_y_next   = dy[PY_W-1] ? -2'sd1 : ((dy != '0) ? 2'sd1 : 2'sd0);
            view_next    = (command == gls_pkg::CMD_VIEW);
        end
        else if (ctrl.advance)
        begin
            pos_x_next = adv_x;
            pos_y_next = adv_y;
            err_next   = adv_err;
        end
        else if (ctrl.back_off)
        begin
            pos_x_next = back_x;
            pos_y_next = back_y;
            err_next   = back_err;
        end
    end

    always_comb
    begin
        reached_next = reached_reg;
        end_x_next   = end_x_reg;
        end_y_next   = end_y_reg;
        if (ctrl.finish)
        begin
            reached_next = at_target;
            end_x_next   = pos_x_reg[CX_W-1:0];
            end_y_next   = pos_y_reg[CY_W-1:0];
        end
        else if (ctrl.finish_now)
        begin
            reached_next = 1'b0;
            end_x_next   = from_x;
            end_y_next   = from_y;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_x_reg   <= pos_x_next;
        pos_y_reg   <= pos_y_next;
        err_reg     <= err_next;
        tgt_x_reg   <= tgt_x_next;
        tgt_y_reg   <= tgt_y_next;
        step_reg    <= step_next;
        delta_reg   <= delta_next;
        major_x_reg <= major_x_next;
        dir_x_reg   <= dir_x_next;
        dir_y_reg   <= dir_y_next;
        view_reg    <= view_next;
        reached_reg <= reached_next;
        end_x_reg   <= end_x_next;
        end_y_reg   <= end_y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            player_x_reg     <= '0;
            player_y_reg     <= '0;
            player_valid_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gls_pkg::REG_PLAYER_X:     player_x_reg     <= cfg_data;
                gls_pkg::REG_PLAYER_Y:     player_y_reg     <= cfg_data[CY_W-1:0];
                gls_pkg::REG_PLAYER_VALID: player_valid_reg <= cfg_data[0];
                default:
                begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    assign target_reached = reached_reg;
    assign end_x          = end_x_reg;
    assign end_y          = end_y_reg;

endmodule

// ===== rtl/grid_line_of_sight.sv =====
// Top level of the grid line of sight block: controller plus datapath.
//
//  channel  | handshake           | word
//  ---------+---------------------+-----------------------------------------------
//  command  | start, busy         | command, cell_*, from_x/y, to_x/y
//  result   | done (one cycle)    | target_reached, end_x, end_y
//  config   | cfg_we              | cfg_index, cfg_data
//
//  A write or unused command answers on the cycle after it is taken.
//  A query reads the map once per line step and once more per back-off.
//  The map memory's single registered read port sets the step rate.
//  Reset clears the controller and player registers; map cells are undefined
//  until written. The result word cannot be stalled.
module grid_line_of_sight (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    command,
    input  logic [gls_pkg::CX_W-1:0]      cell_x,
    input  logic [gls_pkg::CY_W-1:0]      cell_y,
    input  logic                          cell_move_blocked,
    input  logic                          cell_view_blocked,
    input  logic [gls_pkg::CX_W-1:0]      from_x,
    input  logic [gls_pkg::CY_W-1:0]      from_y,
    input  logic [gls_pkg::CX_W-1:0]      to_x,
    input  logic [gls_pkg::CY_W-1:0]      to_y,
    output logic                          done,
    output logic                          target_reached,
    output logic [gls_pkg::CX_W-1:0]      end_x,
    output logic [gls_pkg::CY_W-1:0]      end_y,
    input  logic                          cfg_we,
    input  logic [gls_pkg::IDX_W-1:0]     cfg_index,
    input  logic [gls_pkg::CFG_W-1:0]     cfg_data
);

    gls_pkg::gls_ctrl_t ctrl;
    gls_pkg::gls_stat_t stat;

    gls_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .ctrl    (ctrl),
        .busy    (busy),
        .done    (done)
    );

    gls_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctrl              (ctrl),
        .stat              (stat),
        .command           (command),
        .cell_x            (cell_x),
        .cell_y            (cell_y),
        .cell_move_blocked (cell_move_blocked),
        .cell_view_blocked (cell_view_blocked),
        .from_x            (from_x),
        .from_y            (from_y),
        .to_x              (to_x),
        .to_y              (to_y),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .target_reached    (target_reached),
        .end_x             (end_x),
        .end_y             (end_y)
    );

endmodule
